// ===== hdl/ordered_array_list_defines.svh =====
// assertion macros for the ordered array list checker
// no dependencies; taken in by the checker file
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

// checked outside reset only
`define OLA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define OLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ola_pkg.sv =====
// shared types and constants for the ordered array list
// no dependencies
package ola_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned TYPE_W       = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned GROUP_SIZE   = 32;
  localparam int unsigned GROUP_LOG    = 5;

  typedef enum logic [TYPE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_GET    = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// ===== hdl/ola_intf.sv =====
// request and response channel interfaces for the ordered array list
// depends on ola_pkg
interface ola_req_if;
  import ola_pkg::*;

  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   item_word;

  modport source (output valid, output req_type, output position, output item_word,
                  input ready);
  modport sink   (input valid, input req_type, input position, input item_word,
                  output ready);
endinterface

interface ola_rsp_if #(
  parameter int unsigned CntW = 7
);
  import ola_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   read_word;
  logic [CntW-1:0]     item_count;
  logic                is_full;
  logic                is_empty;

  modport source (output valid, output status, output read_word, output item_count,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input status, input read_word, input item_count,
                  input is_full, input is_empty, output ready);
endinterface

// ===== hdl/ordered_array_list.sv =====
// channel   | dir | payload                                              | handshake
// req_i     | in  | req_type, position, item_word                        | valid/ready
// rsp_o     | out | status, read_word, item_count, is_full, is_empty     | valid/ready
//
// push, pop, insert and remove: the cell chain updates at the transfer edge (pop only
// lowers the count) and the result sits in the output register on the next cycle.
// get passes the registered first level of the read select, then the output register.
// a request is taken when no get is in flight and the output register is free or
// being drained in the same cycle; a stalled response holds the next request.
// reset clears the entry count and the control state only; no clearing pass.
// depends on ola_pkg, ola_intf, ola_cell, ola_read
module ordered_array_list #(
  parameter int unsigned CAPACITY = ola_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ola_req_if.sink   req_i,
  ola_rsp_if.source rsp_o
);
  import ola_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > POS_W) ? CntW : POS_W) + 1;

  localparam logic FSM_IDLE = 1'b0;
  localparam logic FSM_READ = 1'b1;

  logic state_d, state_q;

  logic [CntW-1:0] cnt_d, cnt_q;
  logic [CntW-1:0] cnt_new;
  logic [CmpW-1:0] pos_x, cnt_x, cap_x;
  logic [CntW-1:0] eff_pos;
  status_e         status;
  cell_cmd_t       cmd, cell_cmd;
  logic            is_get, get_ok;
  op_e             op;
  logic            xfer;

  logic                  out_valid_d, out_valid_q;
  logic [STATUS_W-1:0]   out_status_d, out_status_q;
  logic [WORD_W-1:0]     out_word_d, out_word_q;
  logic [CntW-1:0]       out_cnt_d, out_cnt_q;
  logic                  out_full_d, out_full_q;
  logic                  out_empty_d, out_empty_q;
  logic                  get_ok_q;

  logic [CAPACITY-1:0][WORD_W-1:0] cell_data;
  logic [WORD_W-1:0]               rd_word;

  assign op    = op_e'(req_i.req_type);
  assign pos_x = CmpW'(req_i.position);
  assign cnt_x = CmpW'(cnt_q);
  assign cap_x = CmpW'(CAPACITY);

  assign req_i.ready = (state_q == FSM_IDLE) && (!out_valid_q || rsp_o.ready);
  assign xfer        = req_i.valid && req_i.ready;

  always_comb begin
    status  = ST_OK;
    cnt_new = cnt_q;
    cmd     = '0;
    eff_pos = CntW'(pos_x);
    is_get  = 1'b0;
    get_ok  = 1'b0;
    unique case (op)
      OP_PUSH: begin
        if (cnt_x == cap_x) begin
          status = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          eff_pos = cnt_q;
          cnt_new = cnt_q + CntW'(1);
        end
      end
      OP_POP: begin
        if (cnt_q != '0) begin
          cnt_new = cnt_q - CntW'(1);
        end
      end
      OP_INSERT: begin
        if (pos_x >= cap_x) begin
          status = ST_RANGE;
        end else if (cnt_x == cap_x) begin
          status = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status = ST_RANGE;
        end else begin
          cmd.ins = 1'b1;
          cnt_new = cnt_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          cmd.rem = 1'b1;
          cnt_new = cnt_q - CntW'(1);
        end
      end
      OP_GET: begin
        is_get = 1'b1;
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          get_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_cmd = xfer ? cmd : '0;

  // the cell chain: each cell sees both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] lo_w, hi_w;
    if (i == 0) begin : g_bot
      assign lo_w = req_i.item_word;
    end else begin : g_lo
      assign lo_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign hi_w = cell_data[i];
    end else begin : g_hi
      assign hi_w = cell_data[i+1];
    end

    ola_cell #(
      .CellIdx (i),
      .CntW    (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cell_cmd),
      .pos_i  (eff_pos),
      .word_i (req_i.item_word),
      .lo_i   (lo_w),
      .hi_i   (hi_w),
      .data_o (cell_data[i])
    );
  end

  ola_read #(
    .Capacity (CAPACITY)
  ) u_read (
    .clk_i   (clk_i),
    .en_i    (xfer),
    .pos_i   (req_i.position),
    .words_i (cell_data),
    .word_o  (rd_word)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_word_d   = out_word_q;
    out_cnt_d    = out_cnt_q;
    out_full_d   = out_full_q;
    out_empty_d  = out_empty_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (xfer) begin
          cnt_d        = cnt_new;
          out_status_d = status;
          out_word_d   = '0;
          out_cnt_d    = cnt_new;
          out_full_d   = (CmpW'(cnt_new) == cap_x);
          out_empty_d  = (cnt_new == '0);
          if (is_get) begin
            state_d = FSM_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      FSM_READ: begin
        out_valid_d = 1'b1;
        out_word_d  = get_ok_q ? rd_word : '0;
        state_d     = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_word_q   <= out_word_d;
    out_cnt_q    <= out_cnt_d;
    out_full_q   <= out_full_d;
    out_empty_q  <= out_empty_d;
    if (xfer) begin
      get_ok_q <= get_ok;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_word  = out_word_q;
  assign rsp_o.item_count = out_cnt_q;
  assign rsp_o.is_full    = out_full_q;
  assign rsp_o.is_empty   = out_empty_q;

endmodule

// ===== hdl/ola_cell.sv =====
// one entry cell of the list chain: holds a word, takes from a neighbor on shifts
// depends on ola_pkg
module ola_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned CntW    = 7
) (
  input  logic                      clk_i,
  input  ola_pkg::cell_cmd_t        cmd_i,
  input  logic [CntW-1:0]           pos_i,
  input  logic [ola_pkg::WORD_W-1:0] word_i,
  input  logic [ola_pkg::WORD_W-1:0] lo_i,
  input  logic [ola_pkg::WORD_W-1:0] hi_i,
  output logic [ola_pkg::WORD_W-1:0] data_o
);
  import ola_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(CellIdx);

  logic [WORD_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MyIdx == pos_i) begin
        data_d = word_i;
      end else if (MyIdx > pos_i) begin
        // open a gap: take the lower neighbor
        data_d = lo_i;
      end
    end else if (cmd_i.rem && (MyIdx >= pos_i)) begin
      // close the gap: take the upper neighbor
      data_d = hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hdl/ola_read.sv =====
// two-level registered read select over the cell chain
// depends on ola_pkg
module ola_read #(
  parameter int unsigned Capacity = 64
) (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic [ola_pkg::POS_W-1:0]                  pos_i,
  input  logic [Capacity-1:0][ola_pkg::WORD_W-1:0]   words_i,
  output logic [ola_pkg::WORD_W-1:0]                 word_o
);
  import ola_pkg::*;

  localparam int unsigned NumGroups = (Capacity + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
  localparam int unsigned NumPad    = 2 ** GrpW;

  logic [NumPad-1:0][GROUP_SIZE-1:0][WORD_W-1:0] pad;
  logic [NumPad-1:0][WORD_W-1:0]                 grp_q;
  logic [GROUP_LOG-1:0]                          lo_sel;
  logic [POS_W-1:0]                              hi_full;
  logic [GrpW-1:0]                               grp_sel_d, grp_sel_q;

  // entries past the capacity read as zero
  for (genvar k = 0; k < NumPad * GROUP_SIZE; k++) begin : g_pad
    if (k < Capacity) begin : g_used
      assign pad[k / GROUP_SIZE][k % GROUP_SIZE] = words_i[k];
    end else begin : g_zero
      assign pad[k / GROUP_SIZE][k % GROUP_SIZE] = '0;
    end
  end

  assign lo_sel    = pos_i[GROUP_LOG-1:0];
  assign hi_full   = pos_i >> GROUP_LOG;
  assign grp_sel_d = GrpW'(hi_full);

  // first level: one word out of each group
  for (genvar g = 0; g < NumPad; g++) begin : g_grp
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        grp_q[g] <= pad[g][lo_sel];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_sel_q <= grp_sel_d;
    end
  end

  // second level: pick the group
  assign word_o = grp_q[grp_sel_q];

endmodule

// ===== hdl/ola_checker.sv =====
// port-level checks for the ordered array list, bound to the top level
// depends on ola_pkg, ordered_array_list_defines.svh, ordered_array_list
`include "ordered_array_list_defines.svh"

module ola_checker #(
  parameter int unsigned CAPACITY = ola_pkg::CAPACITY_DEF,
  parameter int unsigned CntW     = 7
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ola_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic [ola_pkg::WORD_W-1:0]    rsp_read_word_i,
  input logic [CntW-1:0]               rsp_item_count_i,
  input logic                          rsp_is_full_i,
  input logic                          rsp_is_empty_i
);
  import ola_pkg::*;

  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // a stalled response stays up
  `OLA_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped while stalled")

  `OLA_ASSERT(a_cnt_bound, clk_i, rst_ni, rsp_valid_i |-> rsp_item_count_i <= CapCnt, "item count above capacity")

  `OLA_ASSERT(a_flags, clk_i, rst_ni, rsp_valid_i |-> (rsp_is_full_i == (rsp_item_count_i == CapCnt)) && (rsp_is_empty_i == (rsp_item_count_i == '0)), "full or empty flag disagrees with count")

  // only a good get returns a word
  `OLA_ASSERT(a_word_ok, clk_i, rst_ni, rsp_valid_i && (rsp_read_word_i != '0) |-> rsp_status_i == ST_OK, "nonzero word with error status")

  // the edge after one seen in reset shows no response
  `OLA_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !rsp_valid_i, "response valid during reset")

endmodule

bind ordered_array_list ola_checker #(
  .CAPACITY (CAPACITY),
  .CntW     (CntW)
) u_ola_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_read_word_i  (rsp_o.read_word),
  .rsp_item_count_i (rsp_o.item_count),
  .rsp_is_full_i    (rsp_o.is_full),
  .rsp_is_empty_i   (rsp_o.is_empty)
);
